>>> hw/rtl/bmc_pkg.sv
// shared types, constants and the data set comparison for best master clock selection
`timescale 1ns / 1ps

package bmc_pkg;

  localparam int MAX_RECORDS = 16;
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int IDX_W = 4;
  localparam int SLOT_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int CFG_IDX_W = 8;

  localparam logic [7:0] CLASS_SPLIT = 8'd128;

  typedef enum logic [1:0] {
    PS_MASTER  = 2'd0,
    PS_PASSIVE = 2'd1,
    PS_SLAVE   = 2'd2
  } port_role_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCAL_IDENTITY  = 8'd0,
    CFG_LOCAL_PORT      = 8'd1,
    CFG_LOCAL_PRIORITY1 = 8'd2,
    CFG_LOCAL_PRIORITY2 = 8'd3,
    CFG_LOCAL_CLASS     = 8'd4,
    CFG_LOCAL_ACCURACY  = 8'd5,
    CFG_LOCAL_VARIANCE  = 8'd6,
    CFG_SLAVE_ONLY      = 8'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0] local_identity;
    logic [15:0] local_port;
    logic [7:0]  local_priority1;
    logic [7:0]  local_priority2;
    logic [7:0]  local_class;
    logic [7:0]  local_accuracy;
    logic [15:0] local_variance;
    logic        slave_only;
  } cfg_t;

  typedef struct packed {
    logic [63:0] gm_identity;
    logic [7:0]  gm_priority1;
    logic [7:0]  gm_priority2;
    logic [7:0]  gm_class;
    logic [7:0]  gm_accuracy;
    logic [15:0] gm_variance;
    logic [15:0] hops;
    logic [63:0] sender_identity;
    logic [15:0] sender_port;
  } rec_t;

  // run result handed from the tracker to the decision stage
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } fin_t;

  // true when a compares strictly better than b
  function automatic logic a_better(rec_t a, rec_t b, logic [63:0] rx_id,
                                    logic [15:0] rx_port);
    logic [111:0] ka;
    logic [111:0] kb;
    logic [16:0]  ha;
    logic [16:0]  hb;
    logic         r;
    ka = {a.gm_priority1, a.gm_class, a.gm_accuracy, a.gm_variance,
          a.gm_priority2, a.gm_identity};
    kb = {b.gm_priority1, b.gm_class, b.gm_accuracy, b.gm_variance,
          b.gm_priority2, b.gm_identity};
    ha = {1'b0, a.hops};
    hb = {1'b0, b.hops};
    if (a.gm_identity != b.gm_identity) begin
      r = (ka < kb);
    end else if (ha > hb + 17'd1) begin
      r = 1'b0;
    end else if (ha + 17'd1 < hb) begin
      r = 1'b1;
    end else if (ha > hb) begin
      r = 1'b0;
    end else if (ha < hb) begin
      // b came through more hops: a wins unless b was sent by this port
      r = ({rx_id, rx_port} != {b.sender_identity, b.sender_port});
    end else begin
      r = ({a.sender_identity, a.sender_port} < {b.sender_identity, b.sender_port});
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/bmc_cfg.sv
// configuration registers of the local clock data set
`timescale 1ns / 1ps

module bmc_cfg
  import bmc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  output cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.local_identity  <= 64'd0;
      cfg.local_port      <= 16'd1;
      cfg.local_priority1 <= 8'd128;
      cfg.local_priority2 <= 8'd128;
      cfg.local_class     <= 8'd248;
      cfg.local_accuracy  <= 8'd254;
      cfg.local_variance  <= 16'hffff;
      cfg.slave_only      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOCAL_IDENTITY:  cfg.local_identity  <= cfg_data;
        CFG_LOCAL_PORT:      cfg.local_port      <= cfg_data[15:0];
        CFG_LOCAL_PRIORITY1: cfg.local_priority1 <= cfg_data[7:0];
        CFG_LOCAL_PRIORITY2: cfg.local_priority2 <= cfg_data[7:0];
        CFG_LOCAL_CLASS:     cfg.local_class     <= cfg_data[7:0];
        CFG_LOCAL_ACCURACY:  cfg.local_accuracy  <= cfg_data[7:0];
        CFG_LOCAL_VARIANCE:  cfg.local_variance  <= cfg_data[15:0];
        CFG_SLAVE_ONLY:      cfg.slave_only      <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/bmc_track.sv
// input register and running best record of the current table
`timescale 1ns / 1ps

module bmc_track
  import bmc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  rec_t in_rec,
  input  logic in_last,
  input  cfg_t cfg,
  input  logic fin_free,
  output fin_t fin,
  output rec_t best
);

  logic              s1_valid;
  rec_t              s1_rec;
  logic              s1_last;
  logic [CNT_W-1:0]  count;
  logic [SLOT_W-1:0] slot;
  logic              s1_fire;
  logic              take;
  logic              store;
  logic [SLOT_W-1:0] slot_next;
  logic              fin_valid;
  logic [SLOT_W-1:0] fin_slot;

  assign fin.valid = fin_valid;
  assign fin.slot  = fin_slot;

  // the decision stage reads best, so it must not change while a result waits there
  assign s1_fire  = s1_valid && (!fin_valid || fin_free);
  assign in_stall = s1_valid && !s1_fire;
  assign take     = in_valid && !in_stall;

  always_comb begin
    store     = 1'b0;
    slot_next = slot;
    if (count == '0) begin
      store     = 1'b1;
      slot_next = '0;
    end else if (count < CNT_W'(MAX_RECORDS)) begin
      if (a_better(s1_rec, best, cfg.local_identity, cfg.local_port)) begin
        store     = 1'b1;
        slot_next = SLOT_W'(count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      count     <= '0;
      slot      <= '0;
      fin_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      fin_valid <= (s1_fire && s1_last) || (fin_valid && !fin_free);
      if (s1_fire) begin
        if (s1_last) begin
          count <= '0;
          slot  <= '0;
        end else begin
          slot <= slot_next;
          if (count < CNT_W'(MAX_RECORDS)) begin
            count <= count + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_rec  <= in_rec;
      s1_last <= in_last;
    end
    if (s1_fire && store) begin
      best <= s1_rec;
    end
    if (s1_fire && s1_last) begin
      fin_slot <= slot_next;
    end
  end

endmodule

>>> hw/rtl/bmc_decide.sv
// local data set against the best record, recommended state and result register
`timescale 1ns / 1ps

module bmc_decide
  import bmc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  fin_t             fin,
  input  rec_t             best,
  input  cfg_t             cfg,
  output logic             fin_free,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [IDX_W-1:0] best_index,
  output port_role_t       port_role
);

  logic              s2_valid;
  logic [SLOT_W-1:0] s2_slot;
  port_role_t        s2_state;
  logic              s2_move;
  logic              fin_take;
  rec_t              d0;
  port_role_t        state_next;

  assign s2_move  = s2_valid && (!out_valid || !out_stall);
  assign fin_free = !s2_valid || s2_move;
  // best still holds the closed table while its word waits here
  assign fin_take = fin.valid && fin_free;

  always_comb begin
    d0.gm_identity     = cfg.local_identity;
    d0.gm_priority1    = cfg.local_priority1;
    d0.gm_priority2    = cfg.local_priority2;
    d0.gm_class        = cfg.local_class;
    d0.gm_accuracy     = cfg.local_accuracy;
    d0.gm_variance     = cfg.local_variance;
    d0.hops            = 16'd0;
    d0.sender_identity = cfg.local_identity;
    d0.sender_port     = cfg.local_port;
    if (cfg.slave_only) begin
      state_next = PS_SLAVE;
    end else if (a_better(d0, best, cfg.local_identity, cfg.local_port)) begin
      state_next = PS_MASTER;
    end else if (cfg.local_class < CLASS_SPLIT) begin
      state_next = PS_PASSIVE;
    end else begin
      state_next = PS_SLAVE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fin_take) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
      if (s2_move) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      s2_slot  <= fin.slot;
      s2_state <= state_next;
    end
    if (s2_move) begin
      best_index <= s2_slot[IDX_W-1:0];
      port_role  <= s2_state;
    end
  end

endmodule

>>> hw/rtl/best_master_clock_select.sv
// top level of the best master clock selection block
//
// records arrive on the rec channel (rec_valid / rec_stall), one announce
// record of the foreign master table per word; the word with is_last set
// closes the table. each closed table gives one word on the res channel
// (res_valid / res_stall): the position of the best record in the table and
// the recommended port role. records past MAX_RECORDS are ignored but a
// last one still closes the table.
// the local data set and slave_only are written on the cfg channel
// (cfg_valid / cfg_ready, always ready); the user must write them only
// while the block is idle, the block itself does not enforce this.
// throughput is one record per cycle while rec_stall is low: the running
// best compare sits between the input register and the best record
// register, and the local compare runs in the stage after it.
// when res_stall holds a result, two more closed tables can wait behind it;
// after that the next record stays in the input register and rec_stall
// rises until the result is taken.
// synchronous reset clears the handshake state, the table counters and the
// configuration to its defaults.
`timescale 1ns / 1ps

module best_master_clock_select
  import bmc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rec_valid,
  output logic                 rec_stall,
  input  logic [63:0]          gm_identity,
  input  logic [7:0]           gm_priority1,
  input  logic [7:0]           gm_priority2,
  input  logic [7:0]           gm_class,
  input  logic [7:0]           gm_accuracy,
  input  logic [15:0]          gm_variance,
  input  logic [15:0]          hops,
  input  logic [63:0]          sender_identity,
  input  logic [15:0]          sender_port,
  input  logic                 is_last,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [IDX_W-1:0]     best_index,
  output logic [1:0]           port_role,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  cfg_t       cfg;
  rec_t       in_rec;
  rec_t       best;
  fin_t       fin;
  logic       fin_free;
  port_role_t state;

  assign in_rec.gm_identity     = gm_identity;
  assign in_rec.gm_priority1    = gm_priority1;
  assign in_rec.gm_priority2    = gm_priority2;
  assign in_rec.gm_class        = gm_class;
  assign in_rec.gm_accuracy     = gm_accuracy;
  assign in_rec.gm_variance     = gm_variance;
  assign in_rec.hops            = hops;
  assign in_rec.sender_identity = sender_identity;
  assign in_rec.sender_port     = sender_port;

  assign port_role = state;

  bmc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bmc_track u_track (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rec_valid),
    .in_stall (rec_stall),
    .in_rec   (in_rec),
    .in_last  (is_last),
    .cfg      (cfg),
    .fin_free (fin_free),
    .fin      (fin),
    .best     (best)
  );

  bmc_decide u_decide (
    .clk        (clk),
    .rst        (rst),
    .fin        (fin),
    .best       (best),
    .cfg        (cfg),
    .fin_free   (fin_free),
    .out_valid  (res_valid),
    .out_stall  (res_stall),
    .best_index (best_index),
    .port_role  (state)
  );

endmodule

>>> hw/rtl/bmc_checker.sv
// port level checks for best master clock selection, bound to the top level
`timescale 1ns / 1ps

module bmc_checker
  import bmc_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             rec_stall,
  input logic             res_valid,
  input logic             res_stall,
  input logic [IDX_W-1:0] best_index,
  input logic [1:0]       port_role
);

  // a held result stays on the port
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result word dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(best_index) && $stable(port_role))
    else $error("result word changed while stalled");

  // only master, passive or slave is ever recommended
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (port_role == PS_MASTER) || (port_role == PS_PASSIVE)
                  || (port_role == PS_SLAVE))
    else $error("undefined port role");

  // with the result register empty nothing blocks the record path
  assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !rec_stall)
    else $error("records stalled with no result waiting");

endmodule

bind best_master_clock_select bmc_checker u_bmc_checker (
  .clk        (clk),
  .rst        (rst),
  .rec_stall  (rec_stall),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .best_index (best_index),
  .port_role  (port_role)
);
